FILE: sv/chcb_pkg.sv
// Shared constants, request codes and controller/datapath interface types.
package chcb_pkg;

    // Block configuration.
    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;

    // Field widths of the request and result channels.
    localparam int SYM_W  = 8;
    localparam int LEN_W  = 6;
    localparam int CODE_W = 32;

    // Storage geometry.
    localparam int STORE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SYM_LIMIT   = (SYMBOL_COUNT < STORE_DEPTH) ? SYMBOL_COUNT : STORE_DEPTH;
    localparam int SCAN_W      = $clog2(STORE_DEPTH + 1);
    localparam int LEN_LIMIT   = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int HIST_IDX_W  = ($clog2(LEN_LIMIT) > 0) ? $clog2(LEN_LIMIT) : 1;
    localparam int HIST_W      = $clog2(STORE_DEPTH + 1);
    localparam int LCNT_W      = $clog2(LEN_LIMIT + 1);

    // Request opcodes.
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_store;
        logic accept_read;
        logic clear;
        logic scan_run;
        logic scan_rst;
        logic count_mode;
        logic next_step;
        logic assign_mode;
        logic lookup_rd;
        logic out_load;
    } chcb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic next_last;
        logic out_free;
    } chcb_stat_t;

endpackage

FILE: sv/canonical_huffman_code_builder_unit.sv
// Top level of the canonical Huffman code builder: controller plus datapath.
//
// The block keeps a code length for each of 256 byte symbols and hands out
// their canonical Huffman codes. A store request (opcode 0) writes one
// symbol's length and produces no result. A read request (opcode 1) returns
// the symbol's code, right aligned, its bit count and an error flag that is
// set when the current length set is over-subscribed or holds a length above
// 32. Symbols of length zero, or of a length above the limit, read as code 0
// with bit count 0. A read against an up-to-date table passes through a
// lookup state and a result state that loads the result register; the request
// side is not ready again until the block is back in idle.
// The first read after reset or after any store rebuilds the table first:
// a clear state empties the length histogram, then the rebuild walks the
// length memory twice through its single read port (256 reads and a drain of
// the read pipeline each time), once to build the length histogram and once
// to hand out codes, with a 32-step pass in between that derives the first
// code of each length.
// The result sits in an output register, so the next request is taken while
// a result still waits for m_ready; a new read only stalls in its result
// state when that register is still full and m_ready is low.
module canonical_huffman_code_builder_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_opcode,
    input  logic [chcb_pkg::SYM_W-1:0]  s_symbol_index,
    input  logic [chcb_pkg::LEN_W-1:0]  s_code_length,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [chcb_pkg::CODE_W-1:0] m_code_bits,
    output logic [chcb_pkg::LEN_W-1:0]  m_code_bit_count,
    output logic                        m_length_error
);
    import chcb_pkg::*;

    chcb_cmd_t  cmd;
    chcb_stat_t stat;

    // The controller owns the handshake on the request side and the
    // rebuild sequence; the table-stale flag lives there too.
    chcb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds every memory and table, plus the result register.
    chcb_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_symbol_index   (s_symbol_index),
        .s_code_length    (s_code_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_code_bits      (m_code_bits),
        .m_code_bit_count (m_code_bit_count),
        .m_length_error   (m_length_error)
    );

`ifndef SYNTHESIS
    // After a read request the request side is not ready again until the block is back in idle.
    a_busy_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_opcode == OP_READ)) |=> !s_ready)
        else $error("request side ready right after a read request");

    // A reported length never exceeds the code length limit.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_code_bit_count <= LEN_W'(LEN_LIMIT)))
        else $error("code bit count above the length limit");

    // An empty code carries no bits.
    a_empty_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_code_bit_count == '0)) |-> (m_code_bits == '0))
        else $error("nonzero code bits with zero bit count");

    // Rebuild commands never overlap a lookup.
    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.lookup_rd |-> !(cmd.scan_run || cmd.next_step || cmd.clear))
        else $error("lookup issued during a rebuild");
`endif

endmodule

FILE: sv/chcb_ctrl.sv
// Controller state machine that sequences request handling and table rebuilds.
module chcb_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  chcb_pkg::chcb_stat_t stat,
    output chcb_pkg::chcb_cmd_t  cmd
);
    import chcb_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CLEAR  = 7'b0000010,
        ST_COUNT  = 7'b0000100,
        ST_NEXT   = 7'b0001000,
        ST_ASSIGN = 7'b0010000,
        ST_LOOKUP = 7'b0100000,
        ST_RESULT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   stale_reg, stale_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        stale_next = stale_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_opcode == OP_STORE) begin
                        cmd.accept_store = 1'b1;
                        stale_next       = 1'b1;
                    end else begin
                        cmd.accept_read = 1'b1;
                        state_next      = stale_reg ? ST_CLEAR : ST_LOOKUP;
                    end
                end
            end
            ST_CLEAR: begin
                cmd.clear  = 1'b1;
                state_next = ST_COUNT;
            end
            ST_COUNT: begin
                cmd.scan_run   = 1'b1;
                cmd.count_mode = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                cmd.next_step = 1'b1;
                cmd.scan_rst  = 1'b1;
                if (stat.next_last) begin
                    state_next = ST_ASSIGN;
                end
            end
            ST_ASSIGN: begin
                cmd.scan_run    = 1'b1;
                cmd.assign_mode = 1'b1;
                if (stat.scan_done) begin
                    stale_next = 1'b0;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup_rd = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_RESULT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            stale_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            stale_reg <= stale_next;
        end
    end

endmodule

FILE: sv/chcb_datapath.sv
// Datapath: length and code memories, length histogram, next-code table, result register.
module chcb_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  chcb_pkg::chcb_cmd_t          cmd,
    output chcb_pkg::chcb_stat_t         stat,
    input  logic [chcb_pkg::SYM_W-1:0]   s_symbol_index,
    input  logic [chcb_pkg::LEN_W-1:0]   s_code_length,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [chcb_pkg::CODE_W-1:0]  m_code_bits,
    output logic [chcb_pkg::LEN_W-1:0]   m_code_bit_count,
    output logic                         m_length_error
);
    import chcb_pkg::*;

    // Length store: memory plus one valid bit per entry so that reset reads as zero.
    logic [LEN_W-1:0]       len_mem_reg [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] len_vld_reg;
    logic [LEN_W-1:0]       len_q_reg;
    logic                   len_vq_reg;

    // Code store: written by each rebuild for every symbol with a usable length.
    logic [CODE_W-1:0] code_mem_reg [STORE_DEPTH];
    logic [CODE_W-1:0] code_q_reg;

    logic [HIST_W-1:0] hist_reg [LEN_LIMIT];
    logic [CODE_W-1:0] next_reg [LEN_LIMIT];

    logic [SCAN_W-1:0] scan_cnt_reg;
    logic              pipe_vld_reg;
    logic [ADDR_W-1:0] pipe_addr_reg;
    logic [LCNT_W-1:0] len_cnt_reg;
    logic [CODE_W:0]   code_acc_reg;
    logic [HIST_W-1:0] prev_hist_reg;
    logic              err_reg;
    logic [ADDR_W-1:0] sym_reg;
    logic              sym_ok_reg;

    logic              out_vld_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_err_reg;

    logic                  wr_sym_ok;
    logic                  scan_issue;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [LEN_W-1:0]      len_rd;
    logic                  len_usable;
    logic                  len_over;
    logic [HIST_IDX_W-1:0] len_idx;
    logic [HIST_IDX_W-1:0] step_idx;
    logic [HIST_IDX_W-1:0] hist_idx;
    logic [HIST_W-1:0]     hist_cur;
    logic [CODE_W:0]       code_sum;
    logic [CODE_W:0]       code_l;
    logic [CODE_W+1:0]     space_chk;
    logic [CODE_W+1:0]     space_lim;
    logic [CODE_W-1:0]     next_cur;
    logic [CODE_W-1:0]     code_mask;
    logic [LEN_W-1:0]      mask_shift;

    assign wr_sym_ok  = ({1'b0, s_symbol_index} < (SYM_W + 1)'(SYM_LIMIT));
    assign scan_issue = cmd.scan_run && (scan_cnt_reg < SCAN_W'(SYM_LIMIT));
    assign rd_en      = cmd.lookup_rd || scan_issue;
    assign rd_addr    = cmd.lookup_rd ? sym_reg : scan_cnt_reg[ADDR_W-1:0];

    assign len_rd     = len_vq_reg ? len_q_reg : '0;
    assign len_usable = (len_rd != '0) && (len_rd <= LEN_W'(LEN_LIMIT));
    assign len_over   = (len_rd > LEN_W'(LEN_LIMIT));
    assign len_idx    = HIST_IDX_W'(len_rd - 1'b1);
    assign step_idx   = HIST_IDX_W'(len_cnt_reg - 1'b1);
    assign hist_idx   = cmd.next_step ? step_idx : len_idx;
    assign hist_cur   = hist_reg[hist_idx];
    assign next_cur   = next_reg[len_idx];

    // First code of each length: (previous first code + previous count) shifted left.
    // Kept one bit wider than a code; an overflow there is already flagged.
    assign code_sum  = code_acc_reg + (CODE_W + 1)'(prev_hist_reg);
    assign code_l    = (len_cnt_reg == LCNT_W'(1)) ? '0 : {code_sum[CODE_W-1:0], 1'b0};
    assign space_chk = {1'b0, code_l} + (CODE_W + 2)'(hist_cur);
    assign space_lim = (CODE_W + 2)'(1) << len_cnt_reg;

    assign mask_shift = LEN_W'(CODE_W) - len_rd;
    assign code_mask  = {CODE_W{1'b1}} >> mask_shift;

    always_ff @(posedge aclk) begin
        if (cmd.accept_store && wr_sym_ok) begin
            len_mem_reg[s_symbol_index] <= s_code_length;
        end
        if (rd_en) begin
            len_q_reg  <= len_mem_reg[rd_addr];
            len_vq_reg <= len_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_vld_reg <= '0;
        end else if (cmd.accept_store && wr_sym_ok) begin
            len_vld_reg[s_symbol_index] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.assign_mode && pipe_vld_reg && len_usable) begin
            code_mem_reg[pipe_addr_reg] <= next_cur & code_mask;
        end
        if (cmd.lookup_rd) begin
            code_q_reg <= code_mem_reg[sym_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            for (int i = 0; i < LEN_LIMIT; i++) begin
                hist_reg[i] <= '0;
            end
        end else if (cmd.count_mode && pipe_vld_reg && len_usable) begin
            hist_reg[hist_idx] <= hist_cur + 1'b1;
        end
        if (cmd.next_step) begin
            next_reg[step_idx] <= code_l[CODE_W-1:0];
        end else if (cmd.assign_mode && pipe_vld_reg && len_usable) begin
            next_reg[len_idx] <= next_cur + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.next_step) begin
            code_acc_reg  <= code_l;
            prev_hist_reg <= hist_cur;
        end
        if (scan_issue) begin
            pipe_addr_reg <= scan_cnt_reg[ADDR_W-1:0];
        end
        if (cmd.accept_read) begin
            sym_reg    <= s_symbol_index;
            sym_ok_reg <= wr_sym_ok;
        end
        if (cmd.out_load) begin
            out_code_reg <= (sym_ok_reg && len_usable) ? code_q_reg : '0;
            out_len_reg  <= (sym_ok_reg && len_usable) ? len_rd : '0;
            out_err_reg  <= err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg <= '0;
            pipe_vld_reg <= 1'b0;
            len_cnt_reg  <= LCNT_W'(1);
            err_reg      <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (cmd.clear || cmd.scan_rst) begin
                scan_cnt_reg <= '0;
                pipe_vld_reg <= 1'b0;
            end else if (cmd.scan_run) begin
                pipe_vld_reg <= scan_issue;
                if (scan_issue) begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
            end
            if (cmd.clear) begin
                len_cnt_reg <= LCNT_W'(1);
            end else if (cmd.next_step) begin
                len_cnt_reg <= len_cnt_reg + 1'b1;
            end
            if (cmd.clear) begin
                err_reg <= 1'b0;
            end else if (cmd.count_mode && pipe_vld_reg && len_over) begin
                err_reg <= 1'b1;
            end else if (cmd.next_step && (space_chk > space_lim)) begin
                err_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign stat.scan_done = (scan_cnt_reg == SCAN_W'(SYM_LIMIT)) && !pipe_vld_reg;
    assign stat.next_last = (len_cnt_reg == LCNT_W'(LEN_LIMIT));
    assign stat.out_free  = !out_vld_reg || m_ready;

    assign m_valid          = out_vld_reg;
    assign m_code_bits      = out_code_reg;
    assign m_code_bit_count = out_len_reg;
    assign m_length_error   = out_err_reg;

endmodule
